// ===== sv/sicxe_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sicxe_pkg
// Shared types, constants and the opcode format table of the SIC/XE
// instruction decoder.
// ---------------------------------------------------------------------------
package sicxe_pkg;

  localparam int unsigned AddrWidth = 20;
  localparam int unsigned DispWidth = 12;

  // Opcode indexes (opcode with the two low bits dropped) that load trackers
  localparam logic [5:0] OpIdxLdx = 6'd1;
  localparam logic [5:0] OpIdxLdb = 6'd26;

  // Format class coming out of the opcode table
  typedef enum logic [1:0] {
    FMT_NONE      = 2'd0,
    FMT_ONE       = 2'd1,
    FMT_TWO       = 2'd2,
    FMT_THREE_FOUR = 2'd3
  } fmt_class_e;

  // Encoded instr_format field
  localparam logic [1:0] InstrFmt1 = 2'd0;
  localparam logic [1:0] InstrFmt2 = 2'd1;
  localparam logic [1:0] InstrFmt3 = 2'd2;
  localparam logic [1:0] InstrFmt4 = 2'd3;

  // Encoded address_kind field
  localparam logic [1:0] KindSimple    = 2'd0;
  localparam logic [1:0] KindImmediate = 2'd1;
  localparam logic [1:0] KindIndirect  = 2'd2;

  // Input item, last field in the lowest bits
  typedef struct packed {
    logic [3:0]           pad;
    logic [AddrWidth-1:0] instr_address;
    logic [31:0]          instr_bytes;
  } in_item_t;

  // Result item, last field in the lowest bits
  typedef struct packed {
    logic [1:0]           address_kind;
    logic [AddrWidth-1:0] target_address;
    logic [3:0]           reg_second;
    logic [3:0]           reg_first;
    logic [5:0]           flag_bits;
    logic [2:0]           instr_length;
    logic [1:0]           instr_format;
    logic [5:0]           opcode_index;
    logic                 opcode_known;
  } out_item_t;

  // Fixed opcode table: format class per opcode index
  function automatic fmt_class_e fmt_lookup(input logic [5:0] idx);
    fmt_class_e cls;
    case (idx) inside
      [6'd0:6'd34], [6'd52:6'd56], 6'd58, 6'd59: cls = FMT_THREE_FOUR;
      [6'd36:6'd46]:                             cls = FMT_TWO;
      [6'd48:6'd50], [6'd60:6'd62]:              cls = FMT_ONE;
      default:                                   cls = FMT_NONE;
    endcase
    return cls;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sicxe_instruction_decoder.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sicxe_instruction_decoder
// Decodes one SIC/XE instruction window per transfer and tracks B and X.
// ---------------------------------------------------------------------------
// One instruction window (first byte in bits 31..24) and its address enter
// per transfer; one decoded result leaves per transfer. An item passes through
// the input register and then the result register, with
// the opcode table lookup, field split and the three-input target add in
// between. A new item is taken every cycle while the result side keeps up.
// The base and index trackers load on LDB/LDX as the item moves into the
// result register, so the very next item already sees the new value.
// ---------------------------------------------------------------------------
module sicxe_instruction_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // instr_bytes [31:0], instr_address [51:32], zero [55:52]
  input  wire logic [55:0] s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // opcode_known [0], opcode_index [6:1], instr_format [8:7],
  // instr_length [11:9], flag_bits [17:12], reg_first [21:18],
  // reg_second [25:22], target_address [45:26], address_kind [47:46]
  output logic [47:0]      m_axis_tdata_o
);

  localparam int unsigned AW = sicxe_pkg::AddrWidth;
  localparam int unsigned DW = sicxe_pkg::DispWidth;

  logic                     in_valid_q;
  sicxe_pkg::in_item_t      in_item_q;
  logic                     out_valid_q;
  sicxe_pkg::out_item_t     out_item_q, out_item_d;
  logic [AW-1:0]            base_q, base_d;
  logic [AW-1:0]            index_q, index_d;
  logic                     out_free;
  logic                     advance;

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign advance         = in_valid_q && out_free;
  assign s_axis_tready_o = !in_valid_q || out_free;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_item_q;

  // Decode
  logic [7:0]             b0, b1, b2, b3;
  logic [5:0]             idx;
  sicxe_pkg::fmt_class_e  cls;
  logic                   fn, fi, fx, fb, fp, fe;
  logic [DW-1:0]          d12;
  logic [2:0]             len;
  logic [AW-1:0]          op_a, op_b, op_x, ta;

  always_comb begin
    b0  = in_item_q.instr_bytes[31:24];
    b1  = in_item_q.instr_bytes[23:16];
    b2  = in_item_q.instr_bytes[15:8];
    b3  = in_item_q.instr_bytes[7:0];
    idx = b0[7:2];
    cls = sicxe_pkg::fmt_lookup(idx);
    fn  = b0[1];
    fi  = b0[0];
    fx  = b1[7];
    fb  = b1[6];
    fp  = b1[5];
    fe  = b1[4];
    d12 = {b1[3:0], b2};
    len = fe ? 3'd4 : 3'd3;

    // Select the two address terms; b wins over p
    if (fb) begin
      op_a = base_q;
      op_b = {{(AW-DW){1'b0}}, d12};
    end else if (fp) begin
      op_a = in_item_q.instr_address + {{(AW-3){1'b0}}, len};
      op_b = {{(AW-DW){d12[DW-1]}}, d12};
    end else begin
      op_a = fe ? {d12, b3} : {{(AW-DW){1'b0}}, d12};
      op_b = '0;
    end
    op_x = fx ? index_q : '0;
    ta   = op_a + op_b + op_x;

    out_item_d = '0;
    base_d     = base_q;
    index_d    = index_q;
    case (cls)
      sicxe_pkg::FMT_ONE: begin
        out_item_d.opcode_known = 1'b1;
        out_item_d.opcode_index = idx;
        out_item_d.instr_format = sicxe_pkg::InstrFmt1;
        out_item_d.instr_length = 3'd1;
      end
      sicxe_pkg::FMT_TWO: begin
        out_item_d.opcode_known = 1'b1;
        out_item_d.opcode_index = idx;
        out_item_d.instr_format = sicxe_pkg::InstrFmt2;
        out_item_d.instr_length = 3'd2;
        out_item_d.reg_first    = b1[7:4];
        out_item_d.reg_second   = b1[3:0];
      end
      sicxe_pkg::FMT_THREE_FOUR: begin
        out_item_d.opcode_known   = 1'b1;
        out_item_d.opcode_index   = idx;
        out_item_d.instr_format   = fe ? sicxe_pkg::InstrFmt4 : sicxe_pkg::InstrFmt3;
        out_item_d.instr_length   = len;
        out_item_d.flag_bits      = {fn, fi, fx, fb, fp, fe};
        out_item_d.target_address = ta;
        if (fi && !fn) begin
          out_item_d.address_kind = sicxe_pkg::KindImmediate;
        end else if (fn && !fi) begin
          out_item_d.address_kind = sicxe_pkg::KindIndirect;
        end else begin
          out_item_d.address_kind = sicxe_pkg::KindSimple;
        end
        if (idx == sicxe_pkg::OpIdxLdb) begin
          base_d = ta;
        end else if (idx == sicxe_pkg::OpIdxLdx) begin
          index_d = ta;
        end
      end
      default: begin
        out_item_d = '0;
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q <= s_axis_tdata_i;
    end
  end

  // Result register and trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      base_q      <= '0;
      index_q     <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        base_q  <= base_d;
        index_q <= index_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= out_item_d;
    end
  end

endmodule
`default_nettype wire
